// ===== design/ezr_pkg.sv =====
`default_nettype none
package ezr_pkg;

  localparam int CordicIters = 16;
  localparam int ZW = 20;
  localparam int XW = 27;
  localparam logic signed [ZW-1:0] PiQ16 = 20'sd205887;
  localparam logic signed [ZW-1:0] PiHalfQ16 = 20'sd102944;
  localparam logic signed [XW-1:0] GainQ24 = 27'sd10188014;
  localparam logic signed [15:0] OneQ14 = 16'sd16384;
  localparam int PipeStages = 8;

  typedef struct packed {
    logic signed [15:0] angle_first;
    logic signed [15:0] angle_second;
    logic signed [15:0] angle_third;
  } ezr_in_t;

  typedef struct packed {
    logic signed [15:0] m_r0_c0;
    logic signed [15:0] m_r0_c1;
    logic signed [15:0] m_r0_c2;
    logic signed [15:0] m_r1_c0;
    logic signed [15:0] m_r1_c1;
    logic signed [15:0] m_r1_c2;
    logic signed [15:0] m_r2_c0;
    logic signed [15:0] m_r2_c1;
    logic signed [15:0] m_r2_c2;
  } ezr_out_t;

  typedef struct packed {
    logic signed [15:0] s;
    logic signed [15:0] c;
  } ezr_sc_t;

  function automatic logic signed [ZW-1:0] atan_q16(input int i);
    case (i)
      0: atan_q16 = 20'sd51472;
      1: atan_q16 = 20'sd30386;
      2: atan_q16 = 20'sd16055;
      3: atan_q16 = 20'sd8150;
      4: atan_q16 = 20'sd4091;
      5: atan_q16 = 20'sd2047;
      6: atan_q16 = 20'sd1024;
      7: atan_q16 = 20'sd512;
      8: atan_q16 = 20'sd256;
      9: atan_q16 = 20'sd128;
      10: atan_q16 = 20'sd64;
      11: atan_q16 = 20'sd32;
      12: atan_q16 = 20'sd16;
      13: atan_q16 = 20'sd8;
      14: atan_q16 = 20'sd4;
      default: atan_q16 = 20'sd2;
    endcase
  endfunction

  function automatic logic signed [15:0] sat_one48(input logic signed [47:0] v);
    if (v > 48'sd16384) sat_one48 = OneQ14;
    else if (v < -48'sd16384) sat_one48 = -OneQ14;
    else sat_one48 = v[15:0];
  endfunction

endpackage
`default_nettype wire

// ===== design/ezr_cordic.sv =====
`default_nettype none
// Four-iteration-per-stage CORDIC sine/cosine, 5 register stages.
module ezr_cordic import ezr_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  en,
  input  wire logic signed [15:0]    ang,
  output ezr_sc_t                    sc
);

  // The residual angle is dropped after the last stage, so z has one register fewer.
  logic signed [ZW-1:0] z_r   [0:3];
  logic signed [XW-1:0] x_r   [0:4];
  logic signed [XW-1:0] y_r   [0:4];
  logic                 flip_r[0:4];

  logic signed [ZW-1:0] z0;
  logic                 f0;

  always_comb begin
    z0 = {{(ZW-19){ang[15]}}, ang, 3'b000};
    f0 = 1'b0;
    if (z0 > PiHalfQ16) begin
      z0 = z0 - PiQ16;
      f0 = 1'b1;
    end else if (z0 < -PiHalfQ16) begin
      z0 = z0 + PiQ16;
      f0 = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      z_r[0] <= z0;
      x_r[0] <= GainQ24;
      y_r[0] <= '0;
      flip_r[0] <= f0;
    end
  end

  for (genvar g = 0; g < 4; g++) begin : g_stage
    logic signed [ZW-1:0] zn;
    logic signed [XW-1:0] xn, yn, dx, dy;
    always_comb begin
      zn = z_r[g];
      xn = x_r[g];
      yn = y_r[g];
      for (int k = 0; k < 4; k++) begin
        dx = yn >>> (g*4 + k);
        dy = xn >>> (g*4 + k);
        if (zn >= 0) begin
          xn = xn - dx;
          yn = yn + dy;
          zn = zn - atan_q16(g*4 + k);
        end else begin
          xn = xn + dx;
          yn = yn - dy;
          zn = zn + atan_q16(g*4 + k);
        end
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        x_r[g+1] <= xn;
        y_r[g+1] <= yn;
        flip_r[g+1] <= flip_r[g];
      end
    end
    if (g < 3) begin : g_z
      always_ff @(posedge clk) begin
        if (en) begin
          z_r[g+1] <= zn;
        end
      end
    end
  end

  logic signed [47:0] xr, yr;
  logic signed [15:0] xs, ys;
  always_comb begin
    xr = 48'((48'(x_r[4]) + 48'sd512) >>> 10);
    yr = 48'((48'(y_r[4]) + 48'sd512) >>> 10);
    xs = sat_one48(xr);
    ys = sat_one48(yr);
    sc.c = flip_r[4] ? -xs : xs;
    sc.s = flip_r[4] ? -ys : ys;
  end

endmodule
`default_nettype wire

// ===== design/ezr_matrix.sv =====
`default_nettype none
// Matrix entries from sines/cosines: pair products, triple products, round.
module ezr_matrix import ezr_pkg::*; (
  input  wire logic      clk,
  input  wire logic      en,
  input  wire ezr_sc_t   sc1,
  input  wire ezr_sc_t   sc2,
  input  wire ezr_sc_t   sc3,
  output ezr_out_t       m
);

  // stage A: pair products (Q.28)
  logic signed [31:0] c1c3_r, s1s3_r, c2s1_r, c1c2_r, c3s1_r, c1s3_r;
  logic signed [31:0] s2s3_r, c3s2_r, s1s2_r, c1s2_r, c2c3_r;
  logic signed [15:0] s1a_r, s3a_r, c3a_r, c2a_r;

  always_ff @(posedge clk) begin
    if (en) begin
      c1c3_r <= sc1.c * sc3.c;
      s1s3_r <= sc1.s * sc3.s;
      c2s1_r <= sc2.c * sc1.s;
      c1c2_r <= sc1.c * sc2.c;
      c3s1_r <= sc3.c * sc1.s;
      c1s3_r <= sc1.c * sc3.s;
      s2s3_r <= sc2.s * sc3.s;
      c3s2_r <= sc3.c * sc2.s;
      s1s2_r <= sc1.s * sc2.s;
      c1s2_r <= sc1.c * sc2.s;
      c2c3_r <= sc2.c * sc3.c;
      s1a_r <= sc1.s;
      s3a_r <= sc3.s;
      c3a_r <= sc3.c;
      c2a_r <= sc2.c;
    end
  end

  // stage B: Q.42 sums
  logic signed [47:0] e_r [0:8];
  always_ff @(posedge clk) begin
    if (en) begin
      e_r[0] <= (48'(c1c3_r) <<< 14) - 48'(c2s1_r) * 48'(s3a_r);
      e_r[1] <= -(48'(c3s1_r) <<< 14) - 48'(c1c2_r) * 48'(s3a_r);
      e_r[2] <= 48'(s2s3_r) <<< 14;
      e_r[3] <= 48'(c2c3_r) * 48'(s1a_r) + (48'(c1s3_r) <<< 14);
      e_r[4] <= 48'(c1c2_r) * 48'(c3a_r) - (48'(s1s3_r) <<< 14);
      e_r[5] <= -(48'(c3s2_r) <<< 14);
      e_r[6] <= 48'(s1s2_r) <<< 14;
      e_r[7] <= 48'(c1s2_r) <<< 14;
      e_r[8] <= 48'(c2a_r) <<< 28;
    end
  end

  logic signed [15:0] q [0:8];
  for (genvar g = 0; g < 9; g++) begin : g_rnd
    assign q[g] = sat_one48((e_r[g] + 48'sd134217728) >>> 28);
  end

  always_comb begin
    m.m_r0_c0 = q[0];
    m.m_r0_c1 = q[1];
    m.m_r0_c2 = q[2];
    m.m_r1_c0 = q[3];
    m.m_r1_c1 = q[4];
    m.m_r1_c2 = q[5];
    m.m_r2_c0 = q[6];
    m.m_r2_c1 = q[7];
    m.m_r2_c2 = q[8];
  end

endmodule
`default_nettype wire

// ===== design/euler_angle_rotation_matrix.sv =====
`default_nettype none
// ZXZ Euler rotation matrix, pipelined.
// Registers from input beat to output register: 5 CORDIC, 2 matrix, 1 out.
// Throughput: one beat per cycle; the pipeline advances whenever the output
// register is empty or being drained, so a stall holds every stage in place.
// Reset: synchronous active-low rst_n clears all valid bits; data is not reset.
module euler_angle_rotation_matrix import ezr_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output      logic     in_ready,
  input  wire ezr_in_t  in_data,
  output      logic     out_valid,
  input  wire logic     out_ready,
  output ezr_out_t      out_data
);

  // Valid bits for the 7 internal stages plus the output register.
  logic [PipeStages-2:0] vld_r;
  logic                  out_valid_r;
  logic                  adv;
  ezr_sc_t               sc1, sc2, sc3;
  ezr_out_t              mat;
  ezr_out_t              out_data_r;

  // Advance the whole pipe when the output slot is free or being taken.
  assign adv      = !out_valid_r || out_ready;
  assign in_ready = adv;

  ezr_cordic u_c1 (.clk(clk), .en(adv), .ang(in_data.angle_first),  .sc(sc1));
  ezr_cordic u_c2 (.clk(clk), .en(adv), .ang(in_data.angle_second), .sc(sc2));
  ezr_cordic u_c3 (.clk(clk), .en(adv), .ang(in_data.angle_third),  .sc(sc3));

  ezr_matrix u_mat (.clk(clk), .en(adv), .sc1(sc1), .sc2(sc2), .sc3(sc3), .m(mat));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      vld_r       <= {vld_r[PipeStages-3:0], in_valid};
      out_valid_r <= vld_r[PipeStages-2];
    end
  end

  // Output register: hold while stalled.
  always_ff @(posedge clk) begin
    if (adv) begin
      out_data_r <= mat;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
`default_nettype wire

// ===== design/ezr_checker.sv =====
`default_nettype none
module ezr_checker import ezr_pkg::*; (
  input wire logic     clk,
  input wire logic     rst_n,
  input wire logic     in_ready,
  input wire logic     out_valid,
  input wire logic     out_ready,
  input wire ezr_out_t out_data
);

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("output beat dropped or changed during stall");

  a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output");

  a_diag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.m_r2_c2 <= OneQ14 && out_data.m_r2_c2 >= -OneQ14)
    else $error("entry out of range");

  a_reset: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output valid after reset");

endmodule

bind euler_angle_rotation_matrix ezr_checker u_ezr_checker (
  .clk(clk), .rst_n(rst_n), .in_ready(in_ready),
  .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
);
`default_nettype wire

// ===== dv/euler_angle_rotation_matrix_chk.sv =====
`timescale 1ns / 1ps
module euler_angle_rotation_matrix_chk import ezr_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  input  logic     in_ready,
  input  ezr_in_t  in_data,
  input  logic     out_valid,
  input  logic     out_ready,
  input  ezr_out_t out_data,
  output int       fail_count,
  output int       pending_count,
  output int       matrix_count
);
  ezr_out_t matrix_q[$];

  function automatic longint floor_shr(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint clamp_one(longint v);
    if (v > 16384) return 16384;
    if (v < -16384) return -16384;
    return v;
  endfunction

  function automatic void sin_cos(input logic signed [15:0] ang, output longint s,
                                  output longint c);
    longint z, x, y, dx, dy;
    bit flip;
    longint atan_tab[16] = '{51472, 30386, 16055, 8150, 4091, 2047, 1024, 512,
                             256, 128, 64, 32, 16, 8, 4, 2};
    z = longint'(ang) * 8;
    x = 10188014;
    y = 0;
    flip = 0;
    if (z > 102944) begin
      z -= 205887;
      flip = 1;
    end else if (z < -102944) begin
      z += 205887;
      flip = 1;
    end
    for (int i = 0; i < 16; i++) begin
      dx = floor_shr(y, i);
      dy = floor_shr(x, i);
      if (z >= 0) begin
        x -= dx; y += dy; z -= atan_tab[i];
      end else begin
        x += dx; y -= dy; z += atan_tab[i];
      end
    end
    x = clamp_one(floor_shr(x + 512, 10));
    y = clamp_one(floor_shr(y + 512, 10));
    c = flip ? -x : x;
    s = flip ? -y : y;
  endfunction

  function automatic logic signed [15:0] q42_round(longint v);
    return 16'(clamp_one(floor_shr(v + (longint'(1) << 27), 28)));
  endfunction

  function automatic ezr_out_t euler_matrix(ezr_in_t a);
    longint s1, c1, s2, c2, s3, c3;
    longint w;
    ezr_out_t m;
    w = 16384;
    sin_cos(a.angle_first, s1, c1);
    sin_cos(a.angle_second, s2, c2);
    sin_cos(a.angle_third, s3, c3);
    m.m_r0_c0 = q42_round(c1 * c3 * w - c2 * s1 * s3);
    m.m_r0_c1 = q42_round(-(c3 * s1 * w) - c1 * c2 * s3);
    m.m_r0_c2 = q42_round(s2 * s3 * w);
    m.m_r1_c0 = q42_round(c2 * c3 * s1 + c1 * s3 * w);
    m.m_r1_c1 = q42_round(c1 * c2 * c3 - s1 * s3 * w);
    m.m_r1_c2 = q42_round(-(c3 * s2 * w));
    m.m_r2_c0 = q42_round(s1 * s2 * w);
    m.m_r2_c1 = q42_round(c1 * s2 * w);
    m.m_r2_c2 = 16'(c2);
    return m;
  endfunction

  task automatic compare_entry(string nm, logic [15:0] exp_v, logic [15:0] act_v);
    if (exp_v !== act_v) begin
      fail_count++;
      $display("%0t %s expected %0d actual %0d", $time, nm, $signed(exp_v),
               $signed(act_v));
    end
  endtask

  assign pending_count = matrix_q.size();

  initial begin
    fail_count = 0;
    matrix_count = 0;
  end

  always @(posedge clk) begin
    ezr_out_t want;
    if (rst_n && in_valid && in_ready) matrix_q.push_back(euler_matrix(in_data));
    if (rst_n && out_valid && out_ready) begin
      matrix_count++;
      if (matrix_q.size() == 0) begin
        fail_count++;
        $display("%0t unexpected beat, expected none actual %h", $time, out_data);
      end else begin
        want = matrix_q.pop_front();
        compare_entry("m_r0_c0", want.m_r0_c0, out_data.m_r0_c0);
        compare_entry("m_r0_c1", want.m_r0_c1, out_data.m_r0_c1);
        compare_entry("m_r0_c2", want.m_r0_c2, out_data.m_r0_c2);
        compare_entry("m_r1_c0", want.m_r1_c0, out_data.m_r1_c0);
        compare_entry("m_r1_c1", want.m_r1_c1, out_data.m_r1_c1);
        compare_entry("m_r1_c2", want.m_r1_c2, out_data.m_r1_c2);
        compare_entry("m_r2_c0", want.m_r2_c0, out_data.m_r2_c0);
        compare_entry("m_r2_c1", want.m_r2_c1, out_data.m_r2_c1);
        compare_entry("m_r2_c2", want.m_r2_c2, out_data.m_r2_c2);
      end
    end
  end
endmodule

// ===== dv/euler_angle_rotation_matrix_tb.sv =====
`timescale 1ns / 1ps
module euler_angle_rotation_matrix_tb;
  import ezr_pkg::*;

  localparam int RandomBeats = 550;
  localparam int CycleLimit = 200000;

  logic     clk;
  logic     rst_n;
  logic     in_valid;
  logic     in_ready;
  ezr_in_t  in_data;
  logic     out_valid;
  logic     out_ready;
  ezr_out_t out_data;
  int       fail_count;
  int       pending_count;
  int       matrix_count;
  int       cycle_count;
  bit       calm;  // set for the closing stretch: no idling on either side

  euler_angle_rotation_matrix dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  euler_angle_rotation_matrix_chk chk (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .fail_count(fail_count), .pending_count(pending_count),
    .matrix_count(matrix_count)
  );

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  // Abort on a hung handshake.
  initial begin
    cycle_count = 0;
    forever begin
      @(posedge clk);
      cycle_count++;
      if (cycle_count > CycleLimit) begin
        $display("euler_angle_rotation_matrix: mismatch");
        $finish;
      end
    end
  end

  // Result side: stall in random bursts, none once calm.
  initial begin
    int burst;
    out_ready = 0;
    @(posedge clk iff rst_n);
    forever begin
      if (!calm && $urandom_range(0, 3) == 0) begin
        burst = $urandom_range(1, 9);
        out_ready <= 0;
        repeat (burst) @(posedge clk);
      end else begin
        out_ready <= 1;
        @(posedge clk);
      end
    end
  end

  // Random angle, weighted toward edges: the +-pi/2 fold points and raw 16-bit extremes.
  function automatic logic signed [15:0] pick_angle();
    case ($urandom_range(0, 9))
      0: return 16'($urandom_range(0, 65535));
      1: return 16'sd12868 + 16'($urandom_range(0, 4)) - 16'sd2;
      2: return -16'sd12868 + 16'($urandom_range(0, 4)) - 16'sd2;
      3: return $urandom_range(0, 1) ? 16'sh7fff - 16'($urandom_range(0, 3))
                                     : 16'sh8000 + 16'($urandom_range(0, 3));
      default: return 16'($urandom_range(0, 51472)) - 16'sd25736;
    endcase
  endfunction

  // Hold one beat until accepted, with an optional idle burst first.
  task automatic send_beat(logic signed [15:0] a1, logic signed [15:0] a2,
                           logic signed [15:0] a3);
    int burst;
    if (!calm && $urandom_range(0, 4) == 0) begin
      burst = $urandom_range(1, 9);
      in_valid <= 0;
      repeat (burst) @(posedge clk);
    end
    in_valid <= 1;
    in_data <= '{angle_first: a1, angle_second: a2, angle_third: a3};
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  initial begin
    logic signed [15:0] corner[8];
    int settle;
    corner = '{16'sd0, 16'sd25736, -16'sd25736, 16'sd12868, -16'sd12868,
               16'sh7fff, 16'sh8000, 16'sd6434};
    calm = 0;
    rst_n = 0;
    in_valid = 0;
    in_data = '0;
    repeat (7) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // Directed: each extreme alone on the first and on the second angle, then triples across all three.
    for (int k = 0; k < 8; k++) send_beat(corner[k], 16'sd0, 16'sd0);
    for (int k = 0; k < 8; k++) send_beat(16'sd0, corner[k], 16'sd0);
    for (int k = 0; k < 8; k++) send_beat(corner[(k + 3) % 8], corner[k], corner[7 - k]);

    for (int n = 0; n < RandomBeats; n++) begin
      if (n == RandomBeats - 60) calm = 1;
      send_beat(pick_angle(), pick_angle(), pick_angle());
    end
    in_valid <= 0;

    settle = 0;
    while (pending_count != 0 && settle < 5000) begin
      @(posedge clk);
      settle++;
    end
    repeat (PipeStages + 4) @(posedge clk);

    $display("Drove %0d angle triples (fold points, 16-bit extremes, random);",
             24 + RandomBeats);
    $display("checked %0d matrices, %0d left outstanding.", matrix_count, pending_count);
    if (fail_count == 0 && pending_count == 0) begin
      $display("euler_angle_rotation_matrix: match");
    end else begin
      $display("euler_angle_rotation_matrix: mismatch");
    end
    $finish;
  end
endmodule
